[hw/rtl/window_sigma_outlier_detector_core_defines.svh]
// Assertion macros shared by the outlier detector RTL.
// Depends on nothing; users supply clk and rst in scope.
`ifndef WINDOW_SIGMA_OUTLIER_DETECTOR_CORE_DEFINES_SVH
`define WINDOW_SIGMA_OUTLIER_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSOD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("wsod: same-cycle check failed");

// next-cycle implication, disabled during reset
`define WSOD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("wsod: next-cycle check failed");

`endif

[hw/rtl/wsod_pkg.sv]
// Types, widths and constants for the window sigma outlier detector.
// No dependencies.
package wsod_pkg;

  localparam int SAMPLE_W = 8;
  localparam int K_W      = 4;
  localparam int SD_W     = 7;
  localparam int SCORE_W  = 2;
  localparam int VAR_W    = 16;
  localparam int ROOT_W   = 8;

  localparam logic [K_W-1:0] K_RESET = 4'd3;

  // early-warning band edges, inclusive upper bounds
  localparam logic [SAMPLE_W-1:0] WARN_LO3 = 8'd40;
  localparam logic [SAMPLE_W-1:0] WARN_LO1 = 8'd50;
  localparam logic [SAMPLE_W-1:0] WARN_MID = 8'd90;
  localparam logic [SAMPLE_W-1:0] WARN_HI1 = 8'd110;
  localparam logic [SAMPLE_W-1:0] WARN_HI2 = 8'd130;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_MEAN,
    ST_SQ,
    ST_DIV_VAR,
    ST_ROOT,
    ST_FINISH
  } st_t;

  function automatic logic [SCORE_W-1:0] warning_of(input logic [SAMPLE_W-1:0] s);
    logic [SCORE_W-1:0] w;
    if (s <= WARN_LO3)      w = 2'd3;
    else if (s <= WARN_LO1) w = 2'd1;
    else if (s <= WARN_MID) w = 2'd0;
    else if (s <= WARN_HI1) w = 2'd1;
    else if (s <= WARN_HI2) w = 2'd2;
    else                    w = 2'd3;
    return w;
  endfunction

endpackage

[hw/rtl/window_sigma_outlier_detector_core.sv]
// Sliding-window outlier detector: window store, serial statistics, band test.
// Depends on wsod_pkg and window_sigma_outlier_detector_core_defines.svh.
//
// Usage:
//   Input channel in_valid/in_stall/sample: one heart-rate request per item.
//   Output channel out_valid/out_stall plus result fields: one result per item.
//   Config channel cfg_valid/cfg_ready/cfg_data writes sigma_multiplier;
//   cfg_ready is always high. Write only while the block is idle.
//   Each item rotates the window twice (sum pass, squared-deviation pass),
//   runs a radix-2 divider by WINDOW_LEN for the mean (8+clog2(N) steps) and
//   the variance (16+clog2(N) steps), then an 8-step bit-pair square root.
//   The window walks, the two divides and the square root run in turn for each
//   item; one item is worked at a time, and in_stall holds off the next
//   request until the block is back in idle.
//   A finished result waits in the output register while the next request is
//   accepted; a result that is ready while the previous one is still stalled
//   holds in the final state until the output register frees.
//   Synchronous reset clears the window, the fill count and out_valid, returns
//   the state to idle, and sets sigma_multiplier to 3.
module window_sigma_outlier_detector_core #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsod_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          outlier,
  output logic                          tested,
  output logic [wsod_pkg::SAMPLE_W-1:0] window_mean,
  output logic [wsod_pkg::SD_W-1:0]     window_sd,
  output logic [wsod_pkg::SCORE_W-1:0]  warning_score,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsod_pkg::K_W-1:0]      cfg_data
);
  import wsod_pkg::*;

  localparam int CW     = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + CW;
  localparam int SQ_W   = VAR_W + CW;
  localparam int CNT_W  = $clog2(SQ_W);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  localparam logic [CNT_W-1:0]  WIN_LAST  = CNT_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0]  MDIV_LAST = CNT_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0]  VDIV_LAST = CNT_W'(SQ_W - 1);
  localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CW:0]       DIVISOR   = (CW + 1)'(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);

  st_t state, state_next;

  logic [SAMPLE_W-1:0] win [WINDOW_LEN];
  logic [FILL_W-1:0]   fill_count;
  logic [K_W-1:0]      sigma_multiplier;
  logic [SAMPLE_W-1:0] smp;
  logic [CNT_W-1:0]    cnt;
  logic [SUM_W-1:0]    sum;
  logic [SQ_W-1:0]     sq;
  logic [SQ_W-1:0]     q;
  logic [CW-1:0]       div_rem;
  logic [SAMPLE_W-1:0] mean;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W:0]     root_rem;

  logic                in_acc;
  logic                out_free;
  logic                step_last;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] diff;
  logic [VAR_W-1:0]    prod;
  logic [SQ_W-1:0]     sq_next;
  logic [CW:0]         div_try;
  logic                div_ge;
  logic [CW-1:0]       div_rem_next;
  logic [SQ_W-1:0]     q_div;
  logic [ROOT_W+2:0]   rt_shift;
  logic [ROOT_W+2:0]   rt_trial;
  logic                rt_ge;
  logic [11:0]         band;
  logic [12:0]         band_hi;
  logic                full;
  logic                outlier_c;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // serial datapath pieces
  assign sum_next = sum + SUM_W'(win[0]);
  assign diff     = (win[0] >= mean) ? (win[0] - mean) : (mean - win[0]);
  assign prod     = VAR_W'(diff) * VAR_W'(diff);
  assign sq_next  = sq + SQ_W'(prod);

  // restoring divide step, constant divisor
  assign div_try      = {div_rem, q[SQ_W-1]};
  assign div_ge       = (div_try >= DIVISOR);
  assign div_rem_next = div_ge ? CW'(div_try - DIVISOR) : CW'(div_try);
  assign q_div        = {q[SQ_W-2:0], div_ge};

  // bit-pair square root step on the low 16 bits of q
  assign rt_shift = {root_rem, q[VAR_W-1 -: 2]};
  assign rt_trial = {1'b0, root, 2'b01};
  assign rt_ge    = (rt_shift >= rt_trial);

  // band test: s < mean - band is s + band < mean
  assign full      = (fill_count == FILL_FULL);
  assign band      = 12'(sigma_multiplier) * 12'(root);
  assign band_hi   = 13'(mean) + 13'(band);
  assign outlier_c = full && ((13'(smp) > band_hi) || (13'(smp) + 13'(band) < 13'(mean)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    step_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_SUM;
      end
      ST_SUM: begin
        step_last = (cnt == WIN_LAST);
        if (step_last) state_next = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        step_last = (cnt == MDIV_LAST);
        if (step_last) state_next = ST_SQ;
      end
      ST_SQ: begin
        step_last = (cnt == WIN_LAST);
        if (step_last) state_next = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        step_last = (cnt == VDIV_LAST);
        if (step_last) state_next = ST_ROOT;
      end
      ST_ROOT: begin
        step_last = (cnt == ROOT_LAST);
        if (step_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      sigma_multiplier <= K_RESET;
      out_valid        <= 1'b0;
      cnt              <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) win[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) sigma_multiplier <= cfg_data;
      cnt <= (state_next != state) ? '0 : cnt + 1'b1;

      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
        if (!full) fill_count <= fill_count + 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // window rotates through tap 0 during both passes, shifts in on finish
      if (state == ST_SUM || state == ST_SQ) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
        win[WINDOW_LEN-1] <= win[0];
      end else if (state == ST_FINISH && out_free) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
        win[WINDOW_LEN-1] <= smp;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          smp <= sample;
          sum <= '0;
          sq  <= '0;
        end
      end
      ST_SUM: begin
        sum <= sum_next;
        if (step_last) begin
          q       <= {sum_next, {(SQ_W - SUM_W){1'b0}}};
          div_rem <= '0;
        end
      end
      ST_DIV_MEAN: begin
        q       <= q_div;
        div_rem <= div_rem_next;
        if (step_last) mean <= q_div[SAMPLE_W-1:0];
      end
      ST_SQ: begin
        sq <= sq_next;
        if (step_last) begin
          q        <= sq_next;
          div_rem  <= '0;
          root     <= '0;
          root_rem <= '0;
        end
      end
      ST_DIV_VAR: begin
        q       <= q_div;
        div_rem <= div_rem_next;
      end
      ST_ROOT: begin
        q <= q << 2;
        if (rt_ge) begin
          root_rem <= (ROOT_W + 1)'(rt_shift - rt_trial);
          root     <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          root_rem <= (ROOT_W + 1)'(rt_shift);
          root     <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          outlier       <= outlier_c;
          tested        <= full;
          window_mean   <= mean;
          window_sd     <= root[SD_W-1:0];
          warning_score <= warning_of(smp);
        end
      end
      default: ;
    endcase
  end

`include "window_sigma_outlier_detector_core_defines.svh"

  `WSOD_ASSERT_NXT(a_accept_starts_sum, in_acc, state == ST_SUM)
  `WSOD_ASSERT_IMP(a_result_from_finish, $rose(out_valid), $past(state == ST_FINISH))
  `WSOD_ASSERT_IMP(a_outlier_needs_test, out_valid && outlier, tested)
  `WSOD_ASSERT_IMP(a_fill_bounded, 1'b1, fill_count <= FILL_FULL)

endmodule

[bench/window_sigma_outlier_detector_core_tb.sv]
// Self-checking bench for window_sigma_outlier_detector_core: a directed table,
// then random heart-rate requests checked against an in-bench window predictor.
// Depends on wsod_pkg and the core RTL only.
module window_sigma_outlier_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsod_pkg::*;

  localparam int WIN_LEN    = 5;
  localparam int DIR_N      = 25;
  localparam int PHASES     = 8;
  localparam int PER_PHASE  = 237;
  localparam int CALM_TAIL  = 150;
  localparam int HOLD_AT    = 15000;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN_WAIT = 60;

  typedef struct packed {
    logic                outlier;
    logic                tested;
    logic [SAMPLE_W-1:0] mean;
    logic [SD_W-1:0]     sd;
    logic [SCORE_W-1:0]  score;
  } verdict_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    bit                  pinned;
    verdict_t            want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                outlier;
  logic                tested;
  logic [SAMPLE_W-1:0] window_mean;
  logic [SD_W-1:0]     window_sd;
  logic [SCORE_W-1:0]  warning_score;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [K_W-1:0]      cfg_data = '0;

  window_sigma_outlier_detector_core #(.WINDOW_LEN(WIN_LEN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .outlier(outlier), .tested(tested), .window_mean(window_mean),
    .window_sd(window_sd), .warning_score(warning_score),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [SAMPLE_W-1:0] hist [WIN_LEN];
  int unsigned         held = 0;
  logic [K_W-1:0]      k_now = K_RESET;

  verdict_t awaited_verdicts [$];
  int       errors = 0;
  bit       calm = 1'b0;

  logic [SAMPLE_W-1:0] base_bpm = 8'd80;
  int                  spread = 3;

  logic [SAMPLE_W-1:0] band_edges [10] = '{
    WARN_LO3, WARN_LO3 + 8'd1, WARN_LO1, WARN_LO1 + 8'd1, WARN_MID,
    WARN_MID + 8'd1, WARN_HI1, WARN_HI1 + 8'd1, WARN_HI2, WARN_HI2 + 8'd1
  };

  // band edges, window fill, flat window with spikes both ways, negative lower bound
  dir_row_t dir_rows [DIR_N] = '{
    '{8'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 2'd3}},
    '{8'd255, 1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 2'd3}},
    '{8'd40,  1'b0, '0}, '{8'd41,  1'b0, '0},
    '{8'd50,  1'b0, '0}, '{8'd51,  1'b0, '0},
    '{8'd90,  1'b0, '0}, '{8'd91,  1'b0, '0},
    '{8'd110, 1'b0, '0}, '{8'd111, 1'b0, '0},
    '{8'd130, 1'b0, '0}, '{8'd131, 1'b0, '0},
    '{8'd100, 1'b0, '0}, '{8'd100, 1'b0, '0}, '{8'd100, 1'b0, '0},
    '{8'd100, 1'b0, '0}, '{8'd100, 1'b0, '0},
    '{8'd101, 1'b1, '{1'b1, 1'b1, 8'd100, 7'd0, 2'd1}},
    '{8'd99,  1'b1, '{1'b1, 1'b1, 8'd100, 7'd0, 2'd1}},
    '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0}
  };

  initial begin
    foreach (hist[i]) hist[i] = '0;
  end

  // statistics of the window before s, band test, then shift s in
  function automatic verdict_t judge_sample(input logic [SAMPLE_W-1:0] s);
    verdict_t v;
    int       sum;
    int       mu;
    int       dev;
    int       sq;
    int       var_q;
    int       root;
    int       band;
    int       j;
    sum = 0;
    for (j = 0; j < WIN_LEN; j++) sum += int'(hist[j]);
    mu = sum / WIN_LEN;
    sq = 0;
    for (j = 0; j < WIN_LEN; j++) begin
      dev = int'(hist[j]) - mu;
      sq += dev * dev;
    end
    var_q = sq / WIN_LEN;
    root = 0;
    while ((root + 1) * (root + 1) <= var_q) root++;
    v.outlier = 1'b0;
    v.tested  = 1'b0;
    if (held >= WIN_LEN) begin
      v.tested = 1'b1;
      band = int'(k_now) * root;
      // signed compare: a lower bound below zero never catches a sample
      if (int'(s) > mu + band || int'(s) < mu - band) v.outlier = 1'b1;
    end
    v.mean = mu[SAMPLE_W-1:0];
    v.sd   = root[SD_W-1:0];
    if (s <= WARN_LO3)      v.score = 2'd3;
    else if (s <= WARN_LO1) v.score = 2'd1;
    else if (s <= WARN_MID) v.score = 2'd0;
    else if (s <= WARN_HI1) v.score = 2'd1;
    else if (s <= WARN_HI2) v.score = 2'd2;
    else                    v.score = 2'd3;
    for (j = 0; j < WIN_LEN - 1; j++) hist[j] = hist[j + 1];
    hist[WIN_LEN - 1] = s;
    if (held < WIN_LEN) held++;
    return v;
  endfunction

  // mostly readings near a drifting baseline so the window fills with a
  // tight spread; the rest are spikes, extremes and warning-band edges
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int pick;
    int t;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      t = int'(base_bpm) + int'($urandom_range(0, 2 * spread)) - spread;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return t[SAMPLE_W-1:0];
    end
    if (pick <= 7) return SAMPLE_W'($urandom_range(0, 255));
    if (pick == 8) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return band_edges[$urandom_range(0, 9)];
  endfunction

  task automatic offer(input logic [SAMPLE_W-1:0] s, input bit pinned,
                       input verdict_t want);
    verdict_t calc;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    calc = judge_sample(s);
    awaited_verdicts.push_back(pinned ? want : calc);
  endtask

  // block is idle once every request has its result back
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_multiplier(input logic [K_W-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    k_now = k;
  endtask

  task automatic flag_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got mean %0d",
                 $time, window_mean);
        errors++;
      end else begin
        want = awaited_verdicts.pop_front();
        if (outlier !== want.outlier) flag_field("outlier", want.outlier, outlier);
        if (tested !== want.tested) flag_field("tested", want.tested, tested);
        if (window_mean !== want.mean) flag_field("window_mean", want.mean, window_mean);
        if (window_sd !== want.sd) flag_field("window_sd", want.sd, window_sd);
        if (warning_score !== want.score)
          flag_field("warning_score", want.score, warning_score);
      end
    end
  end

  // receiver: short stall bursts, plus one long hold-off to back up the input
  initial begin
    int unsigned ticks;
    int          n;
    ticks = 0;
    forever begin
      @(posedge clk);
      ticks++;
      // a short burst may step over HOLD_AT, so match a range
      if (ticks >= HOLD_AT && ticks < HOLD_AT + HOLD_LEN) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        ticks += HOLD_LEN;
        out_stall <= 1'b0;
      end else if (!rst && !calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        ticks += n;
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [K_W-1:0] k_seq [PHASES];
    int             ph;
    int             n;
    k_seq = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0};
    for (ph = 4; ph < PHASES; ph++) k_seq[ph] = K_W'($urandom_range(0, 15));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table runs on the reset multiplier
    for (n = 0; n < DIR_N; n++)
      offer(dir_rows[n].value, dir_rows[n].pinned, dir_rows[n].want);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      set_multiplier(k_seq[ph]);
      for (n = 0; n < PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          base_bpm = SAMPLE_W'($urandom_range(30, 220));
          spread   = $urandom_range(0, 6);
        end
        if (ph == PHASES - 1 && n >= PER_PHASE - CALM_TAIL) calm = 1'b1;
        offer(draw_sample(), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && awaited_verdicts.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
